// ===== sv/pab_pkg.sv =====
`timescale 1ns / 1ps

package pab_pkg;

   localparam int DEF_MAX_VERTICES = 1024;
   localparam int DEF_COORD_WIDTH  = 24;

   // fixed widths of the result fields
   localparam int AREA_W  = 58;
   localparam int TOTAL_W = 11;

   // vertex queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_FIRST,
      KIND_NORMAL,
      KIND_DROP
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     last;
   } tag_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_CLOSE_MUL,
      ST_CLOSE_ADD,
      ST_WAIT_OUT,
      ST_DIV
   } back_state_type;

endpackage

// ===== sv/polygon_area_box_centroid_core.sv =====
// Polygon area, bounding box and centre over a stream of Q12.12 vertices, the
// final one flagged by req_last_vertex; one result per polygon carries twice
// the signed shoelace area, the box, the vertex mean (truncated toward zero),
// the vertex count and an overflow flag set once more than MAX_VERTICES
// vertices arrive (later ones are ignored but a flagged last still closes the
// polygon). A front stage classifies each vertex and holds it in a two-entry
// queue; the back end registers the cross products of a normal vertex and
// then adds them to the area, while first and ignored vertices are taken
// without an area step. On the last vertex the closing edge takes its own
// multiply and add steps, then the bit-serial centre dividers run before
// the result is registered, during which the front queue still accepts up
// to two vertices of the next polygon. A finished result waits in its own
// register, so the back end only stalls on it when the next polygon
// reaches its divide.
`timescale 1ns / 1ps

module polygon_area_box_centroid_core #(
   parameter int MAX_VERTICES = pab_pkg::DEF_MAX_VERTICES,
   parameter int COORD_WIDTH  = pab_pkg::DEF_COORD_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic signed [COORD_WIDTH-1:0]     req_vertex_x,
   input  logic signed [COORD_WIDTH-1:0]     req_vertex_y,
   input  logic                              req_last_vertex,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [pab_pkg::AREA_W-1:0] rsp_double_area,
   output logic signed [COORD_WIDTH-1:0]     rsp_box_min_x,
   output logic signed [COORD_WIDTH-1:0]     rsp_box_max_x,
   output logic signed [COORD_WIDTH-1:0]     rsp_box_min_y,
   output logic signed [COORD_WIDTH-1:0]     rsp_box_max_y,
   output logic signed [COORD_WIDTH-1:0]     rsp_centre_x,
   output logic signed [COORD_WIDTH-1:0]     rsp_centre_y,
   output logic [pab_pkg::TOTAL_W-1:0]       rsp_vertex_total,
   output logic                              rsp_overflowed
);
   import pab_pkg::*;

   logic                          item_valid;
   logic                          item_pop;
   logic signed [COORD_WIDTH-1:0] item_x;
   logic signed [COORD_WIDTH-1:0] item_y;
   tag_type                       item_tag;

   pab_front #(
      .MAX_VERTICES(MAX_VERTICES),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .vertex_x    (req_vertex_x),
      .vertex_y    (req_vertex_y),
      .last_vertex (req_last_vertex),
      .item_valid  (item_valid),
      .item_pop    (item_pop),
      .item_x      (item_x),
      .item_y      (item_y),
      .item_tag    (item_tag)
   );

   pab_back #(
      .MAX_VERTICES(MAX_VERTICES),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item_pop         (item_pop),
      .item_x           (item_x),
      .item_y           (item_y),
      .item_tag         (item_tag),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_double_area  (rsp_double_area),
      .rsp_box_min_x    (rsp_box_min_x),
      .rsp_box_max_x    (rsp_box_max_x),
      .rsp_box_min_y    (rsp_box_min_y),
      .rsp_box_max_y    (rsp_box_max_y),
      .rsp_centre_x     (rsp_centre_x),
      .rsp_centre_y     (rsp_centre_y),
      .rsp_vertex_total (rsp_vertex_total),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule

// ===== sv/pab_front.sv =====
`timescale 1ns / 1ps

module pab_front #(
   parameter int MAX_VERTICES = pab_pkg::DEF_MAX_VERTICES,
   parameter int COORD_WIDTH  = pab_pkg::DEF_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic signed [COORD_WIDTH-1:0] vertex_x,
   input  logic signed [COORD_WIDTH-1:0] vertex_y,
   input  logic                          last_vertex,
   output logic                          item_valid,
   input  logic                          item_pop,
   output logic signed [COORD_WIDTH-1:0] item_x,
   output logic signed [COORD_WIDTH-1:0] item_y,
   output pab_pkg::tag_type              item_tag
);
   import pab_pkg::*;

   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic              accept;
   kind_type          kind_in;

   logic signed [COORD_WIDTH-1:0] x_q_ff [QUEUE_DEPTH];
   logic signed [COORD_WIDTH-1:0] y_q_ff [QUEUE_DEPTH];
   tag_type                       tag_q_ff [QUEUE_DEPTH];

   assign full       = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign accept     = push && !full;
   assign item_valid = (fill_ff != '0);

   // classify against the vertices taken so far in this polygon
   always_comb begin
      if (cnt_ff == '0) begin
         kind_in = KIND_FIRST;
      end else if (cnt_ff == CNT_W'(MAX_VERTICES)) begin
         kind_in = KIND_DROP;
      end else begin
         kind_in = KIND_NORMAL;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (last_vertex) begin
            cnt_in = '0;
         end else if (kind_in != KIND_DROP) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      case ({accept, item_pop})
         2'b10:   fill_in = fill_ff + FILL_W'(1);
         2'b01:   fill_in = fill_ff - FILL_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         fill_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         fill_ff <= fill_in;
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (item_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_q_ff[wr_ptr_ff]   <= vertex_x;
         y_q_ff[wr_ptr_ff]   <= vertex_y;
         tag_q_ff[wr_ptr_ff] <= '{kind: kind_in, last: last_vertex};
      end
   end

   assign item_x   = x_q_ff[rd_ptr_ff];
   assign item_y   = y_q_ff[rd_ptr_ff];
   assign item_tag = tag_q_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("vertex queue fill beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("vertex queue popped while empty");

   assert property (@(posedge clock) disable iff (reset)
      (accept && last_vertex) |=> (cnt_ff == '0))
      else $error("vertex count not cleared after last vertex");
`endif

endmodule

// ===== sv/pab_div.sv =====
`timescale 1ns / 1ps

module pab_div #(
   parameter int DVD_W = 34,
   parameter int DVS_W = 11,
   parameter int QUO_W = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0]        divisor,
   output logic                    done,
   output logic signed [QUO_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [STEP_W-1:0] step_ff;
   logic              done_ff;
   logic              neg_ff;
   logic [DVD_W-1:0]  acc_ff, acc_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [DVD_W-1:0]  mag;
   logic [DVS_W:0]    rem_sh, rem_sub;
   logic              ge;
   logic [DVD_W-1:0]  quo_in;

   // magnitude of the most negative value comes out right as unsigned
   assign mag = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);

   // one restoring step: a quotient bit a cycle, dividend shifted out at the top
   always_comb begin
      rem_sh  = {rem_ff, acc_ff[DVD_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      rem_in  = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      acc_in  = {acc_ff[DVD_W-2:0], ge};
      quo_in  = neg_ff ? (~acc_in + DVD_W'(1)) : acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            step_ff <= STEP_W'(DVD_W);
         end else if (step_ff != '0) begin
            step_ff <= step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= mag;
         rem_ff <= '0;
         dvs_ff <= divisor;
         neg_ff <= dividend[DVD_W-1];
      end else if (step_ff != '0) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
         if (step_ff == STEP_W'(1)) begin
            quo_ff <= quo_in[QUO_W-1:0];
         end
      end
   end

   assign done     = done_ff;
   assign quotient = $signed(quo_ff);

endmodule

// ===== sv/pab_back.sv =====
`timescale 1ns / 1ps

module pab_back #(
   parameter int MAX_VERTICES = pab_pkg::DEF_MAX_VERTICES,
   parameter int COORD_WIDTH  = pab_pkg::DEF_COORD_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   output logic                              item_pop,
   input  logic signed [COORD_WIDTH-1:0]     item_x,
   input  logic signed [COORD_WIDTH-1:0]     item_y,
   input  pab_pkg::tag_type                  item_tag,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [pab_pkg::AREA_W-1:0] rsp_double_area,
   output logic signed [COORD_WIDTH-1:0]     rsp_box_min_x,
   output logic signed [COORD_WIDTH-1:0]     rsp_box_max_x,
   output logic signed [COORD_WIDTH-1:0]     rsp_box_min_y,
   output logic signed [COORD_WIDTH-1:0]     rsp_box_max_y,
   output logic signed [COORD_WIDTH-1:0]     rsp_centre_x,
   output logic signed [COORD_WIDTH-1:0]     rsp_centre_y,
   output logic [pab_pkg::TOTAL_W-1:0]       rsp_vertex_total,
   output logic                              rsp_overflowed
);
   import pab_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int SUM_W  = CW + $clog2(MAX_VERTICES);
   localparam int PROD_W = 2 * CW;
   localparam int WIDE_W = (PROD_W > AREA_W) ? PROD_W : AREA_W;

   back_state_type state_ff, state_in;

   logic signed [CW-1:0]     first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [CW-1:0]     min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic signed [SUM_W-1:0]  sum_x_ff, sum_y_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     ovf_ff;
   logic                     last_ff;
   logic [AREA_W-1:0]        area_ff, area_in;
   logic signed [PROD_W-1:0] p1_ff, p2_ff, prod1, prod2;
   logic signed [CW-1:0]     mul_b1, mul_a2;
   logic signed [WIDE_W-1:0] diff_wide;

   logic                     out_valid_ff;
   logic [AREA_W-1:0]        out_area_ff;
   logic signed [CW-1:0]     out_min_x_ff, out_max_x_ff, out_min_y_ff, out_max_y_ff;
   logic signed [CW-1:0]     out_cx_ff, out_cy_ff;
   logic [TOTAL_W-1:0]       out_total_ff;
   logic                     out_ovf_ff;

   logic                     mul_close, mul_load, area_add, div_start, finish;
   logic                     div_x_done, div_y_done;
   logic signed [CW-1:0]     div_x_quo, div_y_quo;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (item_tag.kind == KIND_NORMAL) begin
                  state_in = ST_ADD;
               end else if (item_tag.last) begin
                  state_in = ST_CLOSE_MUL;
               end
            end
         end
         ST_ADD: begin
            state_in = last_ff ? ST_CLOSE_MUL : ST_IDLE;
         end
         ST_CLOSE_MUL: begin
            state_in = ST_CLOSE_ADD;
         end
         ST_CLOSE_ADD: begin
            state_in = ST_WAIT_OUT;
         end
         ST_WAIT_OUT: begin
            if (!out_valid_ff) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_x_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      item_pop  = 1'b0;
      mul_close = 1'b0;
      mul_load  = 1'b0;
      area_add  = 1'b0;
      div_start = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            item_pop = item_valid;
            mul_load = item_valid && (item_tag.kind == KIND_NORMAL);
         end
         ST_ADD, ST_CLOSE_ADD: begin
            area_add = 1'b1;
         end
         ST_CLOSE_MUL: begin
            mul_close = 1'b1;
            mul_load  = 1'b1;
         end
         ST_WAIT_OUT: begin
            div_start = !out_valid_ff;
         end
         ST_DIV: begin
            finish = div_x_done;
         end
         default: begin
         end
      endcase
   end

   // edge term prev x b.y - b.x x prev.y, b being the new vertex or, to close, the first
   assign mul_b1 = mul_close ? first_y_ff : item_y;
   assign mul_a2 = mul_close ? first_x_ff : item_x;
   assign prod1  = PROD_W'(prev_x_ff) * PROD_W'(mul_b1);
   assign prod2  = PROD_W'(mul_a2) * PROD_W'(prev_y_ff);

   assign diff_wide = WIDE_W'(p1_ff) - WIDE_W'(p2_ff);
   assign area_in   = area_ff + diff_wide[AREA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         area_ff      <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            area_ff  <= '0;
            sum_x_ff <= '0;
            sum_y_ff <= '0;
            cnt_ff   <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            if (area_add) begin
               area_ff <= area_in;
            end
            if (item_pop) begin
               case (item_tag.kind)
                  KIND_FIRST: begin
                     sum_x_ff <= SUM_W'(item_x);
                     sum_y_ff <= SUM_W'(item_y);
                     cnt_ff   <= CNT_W'(1);
                  end
                  KIND_NORMAL: begin
                     sum_x_ff <= sum_x_ff + SUM_W'(item_x);
                     sum_y_ff <= sum_y_ff + SUM_W'(item_y);
                     cnt_ff   <= cnt_ff + CNT_W'(1);
                  end
                  KIND_DROP: begin
                     ovf_ff <= 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         if (item_pop) begin
            last_ff <= item_tag.last;
         end
         if (finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop && (item_tag.kind != KIND_DROP)) begin
         prev_x_ff <= item_x;
         prev_y_ff <= item_y;
         if (item_tag.kind == KIND_FIRST) begin
            first_x_ff <= item_x;
            first_y_ff <= item_y;
            min_x_ff   <= item_x;
            max_x_ff   <= item_x;
            min_y_ff   <= item_y;
            max_y_ff   <= item_y;
         end else begin
            if (item_x < min_x_ff) min_x_ff <= item_x;
            if (item_x > max_x_ff) max_x_ff <= item_x;
            if (item_y < min_y_ff) min_y_ff <= item_y;
            if (item_y > max_y_ff) max_y_ff <= item_y;
         end
      end
      if (mul_load) begin
         p1_ff <= prod1;
         p2_ff <= prod2;
      end
      if (finish) begin
         out_area_ff  <= area_ff;
         out_min_x_ff <= min_x_ff;
         out_max_x_ff <= max_x_ff;
         out_min_y_ff <= min_y_ff;
         out_max_y_ff <= max_y_ff;
         out_cx_ff    <= div_x_quo;
         out_cy_ff    <= div_y_quo;
         out_total_ff <= TOTAL_W'(cnt_ff);
         out_ovf_ff   <= ovf_ff;
      end
   end

   pab_div #(
      .DVD_W(SUM_W),
      .DVS_W(CNT_W),
      .QUO_W(CW)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_x_ff),
      .divisor  (cnt_ff),
      .done     (div_x_done),
      .quotient (div_x_quo)
   );

   pab_div #(
      .DVD_W(SUM_W),
      .DVS_W(CNT_W),
      .QUO_W(CW)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_y_ff),
      .divisor  (cnt_ff),
      .done     (div_y_done),
      .quotient (div_y_quo)
   );

   assign rsp_empty        = !out_valid_ff;
   assign rsp_double_area  = $signed(out_area_ff);
   assign rsp_box_min_x    = out_min_x_ff;
   assign rsp_box_max_x    = out_max_x_ff;
   assign rsp_box_min_y    = out_min_y_ff;
   assign rsp_box_max_y    = out_max_y_ff;
   assign rsp_centre_x     = out_cx_ff;
   assign rsp_centre_y     = out_cy_ff;
   assign rsp_vertex_total = out_total_ff;
   assign rsp_overflowed   = out_ovf_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      div_x_done == div_y_done)
      else $error("centre dividers out of step");

   assert property (@(posedge clock) disable iff (reset)
      finish |-> !out_valid_ff)
      else $error("result register overwritten before transfer");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> $past(item_pop))
      else $error("area add without a vertex taken");

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count beyond limit");
`endif

endmodule
